// File: hw/rtl/vgr_pkg.sv
`timescale 1ns / 1ps

package vgr_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int DIM_W        = 13;
    localparam int COORD_W      = 12;
    localparam int CH_W         = 8;
    localparam int OUT_W        = 9;
    localparam int SQ_W         = 26;
    localparam int QUOT_W       = 34;
    localparam int DIV_STAGES   = 17;
    localparam int DIV_BITS     = 2;
    localparam int RAD_W        = 36;
    localparam int ROOT_W       = 18;
    localparam int SREM_W       = 20;
    localparam int SQRT_STAGES  = 9;
    localparam int SQRT_PAIRS   = 2;
    localparam int GAIN_W       = 18;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 18'h20000;

    localparam logic [9:0] AVG_MUL   = 10'd683;
    localparam int         AVG_SHIFT = 11;

    localparam logic [DIM_W-1:0] RESET_ROWS = 13'd480;
    localparam logic [DIM_W-1:0] RESET_COLS = 13'd640;

    localparam logic REG_IMAGE_ROWS = 1'b0;
    localparam logic REG_IMAGE_COLS = 1'b1;

    typedef struct packed {
        logic            grey;
        logic            mark;
        logic            zero_gain;
        logic [CH_W-1:0] avg;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [QUOT_W-1:0] quot;
        logic [SQ_W-1:0]   gsq;
        side_t             side;
    } div_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] srem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sqrt_t;

endpackage

// File: hw/rtl/vignette_grey_region_pixel_top.sv
`timescale 1ns / 1ps

// Radial vignette with a grey rectangle and a fixed black mark. One pixel per
// clock is taken and one result per clock is given while m_tready is high; the
// pipeline is built of 3 setup stages, 17 divider stages of two quotient bits
// each, 9 square-root stages of two root bits each and 2 output stages. Every
// stage has its own valid and a ready chain, so bubbles close up and the block
// keeps taking pixels while a result waits on m_tready, until every stage is full.
// image_rows and image_cols (index 0 and 1) must be written through cfg_we only
// while no pixel is in flight (the block does not enforce it); values above 4096 act as 4096.
module vignette_grey_region_pixel_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row, col, red, green, blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red_out, green_out, blue_out, zero pad
);
    import vgr_pkg::*;

    logic [DIM_W-1:0] image_rows_reg;
    logic [DIM_W-1:0] image_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg <= RESET_ROWS;
            image_cols_reg <= RESET_COLS;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_ROWS: image_rows_reg <= cfg_wdata;
                REG_IMAGE_COLS: image_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic  div_valid [DIV_STAGES+1];
    logic  div_ready [DIV_STAGES+1];
    div_t  div_data  [DIV_STAGES+1];

    logic  sq_valid [SQRT_STAGES+1];
    logic  sq_ready [SQRT_STAGES+1];
    sqrt_t sq_data  [SQRT_STAGES+1];

    vgr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rows_cfg  (image_rows_reg),
        .cols_cfg  (image_cols_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        vgr_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // quotient becomes the radicand
    assign sq_valid[0]          = div_valid[DIV_STAGES];
    assign div_ready[DIV_STAGES] = sq_ready[0];
    assign sq_data[0].rad       = RAD_W'(div_data[DIV_STAGES].quot);
    assign sq_data[0].srem      = '0;
    assign sq_data[0].root      = '0;
    assign sq_data[0].side      = div_data[DIV_STAGES].side;

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        vgr_sqrt_stage u_sqrt (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[j]),
            .in_ready  (sq_ready[j]),
            .in_data   (sq_data[j]),
            .out_valid (sq_valid[j+1]),
            .out_ready (sq_ready[j+1]),
            .out_data  (sq_data[j+1])
        );
    end

    vgr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid[SQRT_STAGES]),
        .in_ready  (sq_ready[SQRT_STAGES]),
        .in_data   (sq_data[SQRT_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: hw/rtl/vgr_front.sv
`timescale 1ns / 1ps

module vgr_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [vgr_pkg::DIM_W-1:0]  rows_cfg,
    input  logic [vgr_pkg::DIM_W-1:0]  cols_cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [47:0]                in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vgr_pkg::div_t              out_data
);
    import vgr_pkg::*;

    // stage 1: centre offsets, region flags, mean
    logic                   v1_reg;
    logic [DIM_W-1:0]       dr_reg, dr_next;
    logic [DIM_W-1:0]       dc_reg, dc_next;
    logic [COORD_W-1:0]     h_reg, h_next;
    logic [DIM_W-1:0]       cols_reg, cols_next;
    side_t                  side1_reg, side1_next;
    logic                   rdy1;

    // stage 2: squares
    logic                   v2_reg;
    logic [SQ_W-1:0]        drsq_reg, dcsq_reg, hsq_reg, colsq_reg;
    side_t                  side2_reg;
    logic                   rdy2;

    // stage 3: sums and divider setup
    logic                   v3_reg;
    div_t                   d3_reg, d3_next;

    logic [COORD_W-1:0]     row, col;
    logic [CH_W-1:0]        red, green, blue;
    logic [DIM_W-1:0]       rows_s;
    logic [DIM_W-1:0]       tw_row, tw_col;
    logic [1:0]             thr;
    logic [9:0]             sum;
    logic [19:0]            avg_prod;
    logic                   mark;

    assign row   = in_data[11:0];
    assign col   = in_data[23:12];
    assign red   = in_data[31:24];
    assign green = in_data[39:32];
    assign blue  = in_data[47:40];

    always_comb begin
        rows_s    = (rows_cfg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_cfg;
        cols_next = (cols_cfg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_cfg;
        tw_row    = {row, 1'b0};
        tw_col    = {col, 1'b0};
        dr_next   = (tw_row >= rows_s) ? tw_row - rows_s : rows_s - tw_row;
        dc_next   = (tw_col >= cols_next) ? tw_col - cols_next : cols_next - tw_col;
        h_next    = rows_s[DIM_W-1:1];
        // rows / 2000 for rows up to 4096
        if (rows_s >= DIM_W'(4000)) begin
            thr = 2'd2;
        end else if (rows_s >= DIM_W'(2000)) begin
            thr = 2'd1;
        end else begin
            thr = 2'd0;
        end
        sum      = 10'(red) + 10'(green) + 10'(blue);
        avg_prod = 20'(sum) * 20'(AVG_MUL);
        mark = ((((row >= 12'd44) && (row <= 12'd45)) || ((row >= 12'd48) && (row <= 12'd49)))
                && (col >= 12'd550) && (col <= 12'd559))
            || (((row >= 12'd42) && (row <= 12'd51))
                && (((col >= 12'd552) && (col <= 12'd553))
                    || ((col >= 12'd556) && (col <= 12'd557))));
        side1_next.grey = (row > COORD_W'(thr))
            && (15'({row, 1'b0}) < 15'(rows_s) * 15'd3)
            && (col > cols_next[DIM_W-1:1])
            && (15'(col) * 15'd6 < 15'(cols_next) * 15'd5);
        side1_next.mark      = mark;
        side1_next.zero_gain = 1'b0;
        side1_next.avg       = avg_prod[AVG_SHIFT+CH_W-1:AVG_SHIFT];
        side1_next.red       = red;
        side1_next.green     = green;
        side1_next.blue      = blue;
    end

    assign in_ready = !v1_reg || rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dr_reg    <= dr_next;
            dc_reg    <= dc_next;
            h_reg     <= h_next;
            cols_reg  <= cols_next;
            side1_reg <= side1_next;
        end
    end

    assign rdy2 = !v2_reg || rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            drsq_reg  <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
            dcsq_reg  <= SQ_W'(dc_reg) * SQ_W'(dc_reg);
            hsq_reg   <= {SQ_W'(h_reg) * SQ_W'(h_reg)} << 2;
            colsq_reg <= SQ_W'(cols_reg) * SQ_W'(cols_reg);
            side2_reg <= side1_reg;
        end
    end

    logic [SQ_W:0] dsq;

    always_comb begin
        dsq          = (SQ_W+1)'(drsq_reg) + (SQ_W+1)'(dcsq_reg);
        d3_next.gsq  = hsq_reg + colsq_reg;
        d3_next.side = side2_reg;
        // sqrt(dsq/gsq) >= 1 means the gain is clamped to zero
        d3_next.side.zero_gain = dsq >= (SQ_W+1)'(d3_next.gsq);
        d3_next.rem  = d3_next.side.zero_gain ? '0 : dsq[SQ_W-1:0];
        d3_next.quot = '0;
    end

    assign rdy1 = !v3_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy1) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy1) begin
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// File: hw/rtl/vgr_div_stage.sv
`timescale 1ns / 1ps

module vgr_div_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  vgr_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output vgr_pkg::div_t out_data
);
    import vgr_pkg::*;

    logic valid_reg;
    div_t data_reg, data_next;

    always_comb begin
        logic [SQ_W:0] sh;
        data_next = in_data;
        // restoring division, remainder always below gsq
        for (int k = 0; k < DIV_BITS; k++) begin
            sh = {data_next.rem, 1'b0};
            if (sh >= (SQ_W+1)'(data_next.gsq)) begin
                sh = sh - (SQ_W+1)'(data_next.gsq);
                data_next.quot = {data_next.quot[QUOT_W-2:0], 1'b1};
            end else begin
                data_next.quot = {data_next.quot[QUOT_W-2:0], 1'b0};
            end
            data_next.rem = sh[SQ_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/vgr_sqrt_stage.sv
`timescale 1ns / 1ps

module vgr_sqrt_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vgr_pkg::sqrt_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vgr_pkg::sqrt_t out_data
);
    import vgr_pkg::*;

    logic  valid_reg;
    sqrt_t data_reg, data_next;

    always_comb begin
        logic [SREM_W+1:0] cur;
        logic [SREM_W+1:0] trial;
        data_next = in_data;
        // digit-by-digit square root, two radicand bits per digit
        for (int k = 0; k < SQRT_PAIRS; k++) begin
            cur   = {data_next.srem, data_next.rad[RAD_W-1:RAD_W-2]};
            trial = (SREM_W+2)'({data_next.root, 2'b01});
            data_next.rad = {data_next.rad[RAD_W-3:0], 2'b00};
            if (cur >= trial) begin
                cur = cur - trial;
                data_next.root = {data_next.root[ROOT_W-2:0], 1'b1};
            end else begin
                data_next.root = {data_next.root[ROOT_W-2:0], 1'b0};
            end
            data_next.srem = cur[SREM_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/vgr_back.sv
`timescale 1ns / 1ps

module vgr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vgr_pkg::sqrt_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_data
);
    import vgr_pkg::*;

    logic              v1_reg;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    side_t             side_reg;
    logic              rdy1;

    logic              v2_reg;
    logic [OUT_W-1:0]  red_reg, red_next;
    logic [OUT_W-1:0]  green_reg, green_next;
    logic [OUT_W-1:0]  blue_reg, blue_next;

    assign gain_next = in_data.side.zero_gain ? '0 : GAIN_ONE - in_data.root;

    assign in_ready = !v1_reg || rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            gain_reg <= gain_next;
            side_reg <= in_data.side;
        end
    end

    logic [25:0] prod_r, prod_g, prod_b;

    always_comb begin
        prod_r = 26'(side_reg.red) * 26'(gain_reg);
        prod_g = 26'(side_reg.green) * 26'(gain_reg);
        prod_b = 26'(side_reg.blue) * 26'(gain_reg);
        if (side_reg.mark) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end else if (side_reg.grey) begin
            red_next   = OUT_W'(side_reg.avg);
            green_next = OUT_W'(side_reg.avg);
            blue_next  = OUT_W'(side_reg.avg);
        end else begin
            red_next   = prod_r[24:16];
            green_next = prod_g[24:16];
            blue_next  = prod_b[24:16];
        end
    end

    assign rdy1 = !v2_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy1) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy1) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = {5'b0, blue_reg, green_reg, red_reg};

`ifndef SYNTH
    a_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_data.side.zero_gain) |=> (gain_reg == '0))
        else $error("clamped pixel got nonzero gain");

    a_mark_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy1 && side_reg.mark) |=>
            (red_reg == '0 && green_reg == '0 && blue_reg == '0))
        else $error("mark pixel not black");

    a_grey_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy1 && side_reg.grey) |=>
            (red_reg == green_reg && green_reg == blue_reg))
        else $error("grey pixel channels differ");
`endif

endmodule
